// File: design/hrhp_pkg.sv
// Package for the HTTP request header parser: sizes, character codes, types and name tables.
package hrhp_pkg;

  localparam int BUF_DEPTH = 4096;
  localparam int POS_W     = $clog2(BUF_DEPTH + 1);
  localparam int OFF_W     = 12;
  localparam int NUM_HDR   = 4;
  localparam int NAME_W    = 14;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Known header names in lower case, left aligned and padded with zeros.
  localparam logic [8*NAME_W-1:0] KNOWN_NAME [NUM_HDR] = '{
    {"host", 80'd0},
    {"connection", 32'd0},
    {"content-type", 16'd0},
    "content-length"
  };
  localparam logic [3:0] KNOWN_LEN [NUM_HDR] = '{4'd4, 4'd10, 4'd12, 4'd14};

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SKIP_CLR,
    ACT_FINISH,
    ACT_LF_STORE,
    ACT_COLON_NAME,
    ACT_COLON_VALUE,
    ACT_SPACE0,
    ACT_PLAIN
  } action_e;

  typedef struct packed {
    logic [POS_W-1:0]              write_pos;
    logic [POS_W-1:0]              line_start;
    logic [POS_W-1:0]              value_start;
    logic [1:0]                    line_count;
    logic                          skip_line;
    logic                          finished;
    logic                          failed;
    logic [POS_W-1:0]              path_start;
    logic [POS_W-1:0]              version_start;
    logic [NUM_HDR-1:0][POS_W-1:0] header_slot;
    logic [NUM_HDR-1:0]            name_match;
  } state_t;

  typedef struct packed {
    logic                          wr_en;
    logic [OFF_W-1:0]              wr_addr;
    logic [7:0]                    wr_data;
    logic                          done_res;
    logic                          overflow;
    logic [OFF_W-1:0]              path_offset;
    logic [OFF_W-1:0]              version_offset;
    logic [NUM_HDR-1:0][OFF_W-1:0] hdr_offset;
  } result_t;

  localparam state_t STATE_RESET = '{
    write_pos:     '0,
    line_start:    '0,
    value_start:   '0,
    line_count:    '0,
    skip_line:     1'b0,
    finished:      1'b0,
    failed:        1'b0,
    path_start:    '0,
    version_start: '0,
    header_slot:   '0,
    name_match:    '1
  };

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] known_char(input logic [1:0] k, input logic [3:0] i);
    logic [3:0] j;
    j = (i < 4'(NAME_W)) ? 4'(NAME_W - 1) - i : '0;
    return KNOWN_NAME[k][{j, 3'b000} +: 8];
  endfunction

endpackage

// File: design/hrhp_step.sv
// Per-byte next-state and result logic of the header parser.
module hrhp_step (
  input  hrhp_pkg::state_t  cur_i,
  input  logic [7:0]        data_byte_i,
  input  logic              restart_i,
  output hrhp_pkg::state_t  nxt_o,
  output hrhp_pkg::result_t res_o
);
  import hrhp_pkg::*;

  action_e            act;
  logic               stores;
  logic               full;
  logic [7:0]         store_byte;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_inc;
  logic [NUM_HDR-1:0] match_next;
  logic               found_valid;
  logic [1:0]         found_idx;

  always_comb begin
    act = ACT_NONE;
    if (cur_i.finished || cur_i.failed) begin
      act = ACT_NONE;
    end else if (data_byte_i == CHAR_CR) begin
      act = ACT_NONE;
    end else if (data_byte_i == CHAR_LF) begin
      if (cur_i.skip_line) begin
        act = ACT_SKIP_CLR;
      end else if (cur_i.line_start == cur_i.write_pos) begin
        act = ACT_FINISH;
      end else begin
        act = ACT_LF_STORE;
      end
    end else if (data_byte_i == CHAR_COLON) begin
      if (!cur_i.skip_line) begin
        act = (cur_i.value_start == '0) ? ACT_COLON_NAME : ACT_COLON_VALUE;
      end
    end else if (data_byte_i == CHAR_SPACE && cur_i.line_count == 2'd0) begin
      act = ACT_SPACE0;
    end else if (data_byte_i == CHAR_SPACE || data_byte_i == CHAR_TAB) begin
      if (cur_i.value_start != cur_i.write_pos && !cur_i.skip_line) begin
        act = ACT_PLAIN;
      end
    end else if (!cur_i.skip_line) begin
      act = ACT_PLAIN;
    end
  end

  assign stores = (act == ACT_LF_STORE) || (act == ACT_COLON_NAME) || (act == ACT_SPACE0) ||
                  (act == ACT_COLON_VALUE) || (act == ACT_PLAIN);
  assign store_byte = (act == ACT_COLON_VALUE || act == ACT_PLAIN) ? data_byte_i : 8'd0;
  assign full    = cur_i.write_pos >= POS_W'(BUF_DEPTH);
  assign pos     = cur_i.write_pos - cur_i.line_start;
  assign pos_inc = cur_i.write_pos + POS_W'(1);

  always_comb begin
    for (int k = 0; k < NUM_HDR; k++) begin
      match_next[k] = cur_i.name_match[k] &&
                      !(pos >= POS_W'(KNOWN_LEN[k]) ||
                        to_lower(data_byte_i) != known_char(2'(k), pos[3:0]));
    end
  end

  always_comb begin
    found_valid = 1'b0;
    found_idx   = '0;
    for (int k = NUM_HDR - 1; k >= 0; k--) begin
      if (cur_i.name_match[k] && pos == POS_W'(KNOWN_LEN[k])) begin
        found_valid = 1'b1;
        found_idx   = 2'(k);
      end
    end
  end

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    if (restart_i) begin
      nxt_o = STATE_RESET;
    end else if (stores && full) begin
      nxt_o.failed   = 1'b1;
      res_o.overflow = 1'b1;
    end else begin
      if (stores) begin
        res_o.wr_en     = 1'b1;
        res_o.wr_addr   = OFF_W'(cur_i.write_pos);
        res_o.wr_data   = store_byte;
        nxt_o.write_pos = pos_inc;
      end
      case (act)
        ACT_SKIP_CLR: begin
          nxt_o.skip_line = 1'b0;
        end
        ACT_FINISH: begin
          nxt_o.finished = 1'b1;
          res_o.done_res = 1'b1;
        end
        ACT_LF_STORE: begin
          if (cur_i.line_count == 2'd0) begin
            nxt_o.version_start = cur_i.line_start;
          end
          if (cur_i.line_count < 2'd2) begin
            nxt_o.line_count = cur_i.line_count + 2'd1;
          end
          nxt_o.line_start  = pos_inc;
          nxt_o.value_start = '0;
          nxt_o.name_match  = '1;
        end
        ACT_COLON_NAME: begin
          if (found_valid) begin
            nxt_o.header_slot[found_idx] = cur_i.line_start;
            nxt_o.value_start            = cur_i.line_start;
          end else begin
            nxt_o.skip_line = 1'b1;
          end
          nxt_o.write_pos  = cur_i.line_start;
          nxt_o.name_match = '1;
        end
        ACT_SPACE0: begin
          if (cur_i.line_start != '0) begin
            nxt_o.path_start = cur_i.line_start;
          end
          nxt_o.line_start = pos_inc;
          nxt_o.name_match = '1;
        end
        ACT_PLAIN: begin
          if (cur_i.value_start == '0) begin
            nxt_o.name_match = match_next;
          end
        end
        default: begin
        end
      endcase
    end
    res_o.path_offset    = OFF_W'(nxt_o.path_start);
    res_o.version_offset = OFF_W'(nxt_o.version_start);
    for (int k = 0; k < NUM_HDR; k++) begin
      res_o.hdr_offset[k] = OFF_W'(nxt_o.header_slot[k]);
    end
  end

endmodule

// File: design/http_request_header_parser.sv
// Top level of the HTTP request header parser: parser state, result register and handshake.
//
// The input channel carries one raw header byte per beat together with a restart flag.
// A beat with restart set clears all parser state and ignores its byte. Every accepted
// input beat produces exactly one output beat: an optional buffer write (address and
// byte), the done and overflow flags, and the current path, version and known header
// value offsets. The string buffer itself lives outside the block.
// The result of a beat is registered and appears on the output in the cycle after it
// is accepted. Throughput is one byte per cycle while the receiver takes every result,
// set by the single parser state register that is updated once per accepted beat.
// The output register acts as the stage between the two sides, so a new byte is taken
// whenever the output is empty or is being taken in the same cycle. When the receiver
// stalls, the result holds and the input is held off after one waiting result.
// After reset the parser is at the start of the request line with all offsets zero,
// and no output is pending. Once the header completes or the buffer overflows, bytes
// are consumed without effect until a restart beat.
module http_request_header_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  wr_en_o,
  output logic [11:0]           wr_addr_o,
  output logic [7:0]            wr_data_o,
  output logic                  done_res_o,
  output logic                  overflow_o,
  output logic [11:0]           path_offset_o,
  output logic [11:0]           version_offset_o,
  output logic [11:0]           host_offset_o,
  output logic [11:0]           connection_offset_o,
  output logic [11:0]           ctype_offset_o,
  output logic [11:0]           clength_offset_o
);
  import hrhp_pkg::*;

  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    in_accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  hrhp_step u_step (
    .cur_i      (state_q),
    .data_byte_i(data_byte_i),
    .restart_i  (restart_i),
    .nxt_o      (state_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign wr_en_o             = res_q.wr_en;
  assign wr_addr_o           = res_q.wr_addr;
  assign wr_data_o           = res_q.wr_data;
  assign done_res_o          = res_q.done_res;
  assign overflow_o          = res_q.overflow;
  assign path_offset_o       = res_q.path_offset;
  assign version_offset_o    = res_q.version_offset;
  assign host_offset_o       = res_q.hdr_offset[0];
  assign connection_offset_o = res_q.hdr_offset[1];
  assign ctype_offset_o      = res_q.hdr_offset[2];
  assign clength_offset_o    = res_q.hdr_offset[3];

`ifndef ASSERT_OFF
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && restart_i |=> out_valid_o && !wr_en_o && !done_res_o && !overflow_o &&
      path_offset_o == '0 && version_offset_o == '0 && host_offset_o == '0 &&
      connection_offset_o == '0 && ctype_offset_o == '0 && clength_offset_o == '0)
    else $error("restart beat did not give a cleared result");

  a_store_or_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(wr_en_o && overflow_o) && !(done_res_o && (wr_en_o || overflow_o)))
    else $error("write, overflow and done flags overlap");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input held off with no result pending");

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !restart_i && state_q.finished |=> !wr_en_o && !overflow_o && !done_res_o)
    else $error("finished parser still produced activity");
`endif

endmodule
